// ===== rtl/spsl_pkg.sv =====
// Shared types, widths and codes for the stable priority sorted list.
package spsl_pkg;

    // List size and derived widths
    localparam int LIST_DEPTH = 16;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int POS_W      = 4;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Field widths
    localparam int OPCODE_W      = 2;
    localparam int LOCATION_W    = 8;
    localparam int PRIORITY_W    = 16;
    localparam int LABEL_W       = 64;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    // Stream widths, padded to whole bytes
    localparam int S_FIELDS_W = OPCODE_W + LOCATION_W + PRIORITY_W + LABEL_W + POS_W;
    localparam int M_FIELDS_W = STATUS_W + ENTRY_COUNT_W + LOCATION_W + PRIORITY_W + LABEL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } status_t;

    // One list entry
    typedef struct packed {
        logic [LOCATION_W-1:0]        location;
        logic signed [PRIORITY_W-1:0] priority_val;
        logic [LABEL_W-1:0]           label;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        entry_t new_entry;
    } cell_cmd_t;

    // What a cell sees of its left neighbor
    typedef struct packed {
        logic   valid;
        logic   greater;
        entry_t entry;
    } cell_link_t;

endpackage

// ===== rtl/stable_priority_sorted_list.sv =====
// Top level of the stable priority sorted list: cell row, count and result register.
//
//  channel | dir | tdata fields (low bit up)                                  | handshake
//  s_      | in  | opcode 2, location 8, priority_req 16, label_tag 64,       | s_tvalid/s_tready
//          |     | position 4, zero pad 2                                     |
//  m_      | out | status 2, entry_count 5, out_location 8, out_priority 16,  | m_tvalid/m_tready
//          |     | out_label 64, zero pad 1                                   |
//
// Every operation completes in the cycle of its transfer; the result is registered and shows in the next cycle.
// One item per cycle is sustained: all cells compare against the new priority at once.
// Input stalls only while a result is held and m_tready is low.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module stable_priority_sorted_list (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode, location, priority_req, label_tag, position, pad
    input  logic [spsl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, entry_count, out_location, out_priority, out_label, pad
    output logic [spsl_pkg::M_TDATA_W-1:0] m_tdata
);
    import spsl_pkg::*;

    // Unpacked input fields
    opcode_t                  in_op;
    logic [LOCATION_W-1:0]    in_location;
    logic signed [PRIORITY_W-1:0] in_priority;
    logic [LABEL_W-1:0]       in_label;
    logic [POS_W-1:0]         in_position;

    assign in_op       = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign in_location = s_tdata[OPCODE_W +: LOCATION_W];
    assign in_priority = s_tdata[OPCODE_W+LOCATION_W +: PRIORITY_W];
    assign in_label    = s_tdata[OPCODE_W+LOCATION_W+PRIORITY_W +: LABEL_W];
    assign in_position = s_tdata[OPCODE_W+LOCATION_W+PRIORITY_W+LABEL_W +: POS_W];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    status_t          m_status_reg, status_c;
    logic [CNT_W-1:0] m_count_reg;
    entry_t           m_entry_reg, rd_entry;

    logic s_xfer;
    logic is_full;
    logic pos_ok;
    logic [CMP_W-1:0] pos_ext, count_ext;

    cell_cmd_t  cmd;
    entry_t     cell_entry [LIST_DEPTH];
    logic       cell_greater [LIST_DEPTH];
    logic       cell_valid [LIST_DEPTH];
    cell_link_t cell_left [LIST_DEPTH];

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign is_full   = (count_reg == CNT_W'(LIST_DEPTH));
    assign pos_ext   = CMP_W'(in_position);
    assign count_ext = CMP_W'(count_reg);
    assign pos_ok    = (pos_ext < count_ext);

    // Broadcast command
    always_comb begin
        cmd.ins_en                 = s_xfer && (in_op == OP_ADD) && !is_full;
        cmd.rem_en                 = s_xfer && (in_op == OP_REMOVE) && pos_ok;
        cmd.new_entry.location     = in_location;
        cmd.new_entry.priority_val = in_priority;
        cmd.new_entry.label        = in_label;
    end

    // Build the cell row
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        assign cell_valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            // Boundary acts as a live entry that never sorts after the new one
            assign cell_left[i].valid   = 1'b1;
            assign cell_left[i].greater = 1'b0;
            assign cell_left[i].entry   = cmd.new_entry;
        end else begin : g_inner
            assign cell_left[i].valid   = cell_valid[i-1];
            assign cell_left[i].greater = cell_greater[i-1];
            assign cell_left[i].entry   = cell_entry[i-1];
        end

        spsl_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_valid  (cell_valid[i]),
            .shift_sel   (CMP_W'(i) >= pos_ext),
            .left        (cell_left[i]),
            .right_entry (cell_entry[(i + 1 < LIST_DEPTH) ? i + 1 : i]),
            .entry_o     (cell_entry[i]),
            .greater_o   (cell_greater[i])
        );
    end

    // Select the entry at the requested position
    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (CMP_W'(i) == pos_ext) begin
                rd_entry = cell_entry[i];
            end
        end
    end

    // Status and count after the operation
    always_comb begin
        status_c   = ST_OK;
        count_next = count_reg;
        case (in_op)
            OP_ADD: begin
                if (is_full) begin
                    status_c = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!pos_ok) begin
                    status_c = ST_BADPOS;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (!pos_ok) begin
                    status_c = ST_BADPOS;
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
    end

    // Control state: count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                count_reg <= count_next;
            end
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_status_reg <= status_c;
            m_count_reg  <= count_next;
            if ((in_op == OP_READ) && pos_ok) begin
                m_entry_reg <= rd_entry;
            end else begin
                m_entry_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_entry_reg.label,
                                  m_entry_reg.priority_val,
                                  m_entry_reg.location,
                                  ENTRY_COUNT_W'(m_count_reg),
                                  m_status_reg});

    // Count never exceeds the list size
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("live count exceeds list depth");

    // Add to a full list is refused and leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (in_op == OP_ADD) && is_full) |=>
            (m_status_reg == ST_FULL) && (count_reg == $past(count_reg)))
        else $error("add to full list not refused");

    // Every transfer in produces a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> m_valid_reg)
        else $error("result missing after input transfer");

    // Live entries stay in ascending priority order
    for (genvar i = 1; i < LIST_DEPTH; i++) begin : g_order_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            cell_valid[i] |->
                (cell_entry[i-1].priority_val <= cell_entry[i].priority_val))
            else $error("list order broken");
    end

endmodule

// ===== rtl/spsl_cell.sv =====
// One slot of the sorted list: holds an entry and shifts with its neighbors.
module spsl_cell (
    input  logic               aclk,
    input  spsl_pkg::cell_cmd_t  cmd,
    input  logic               cell_valid,
    input  logic               shift_sel,
    input  spsl_pkg::cell_link_t left,
    input  spsl_pkg::entry_t     right_entry,
    output spsl_pkg::entry_t     entry_o,
    output logic               greater_o
);
    import spsl_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Flag a live entry that sorts after the incoming one
    assign greater_o = cell_valid &&
                       (entry_reg.priority_val > cmd.new_entry.priority_val);
    assign entry_o   = entry_reg;

    // Pick next content: shift right on insert, take new at the slot, shift left on remove
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins_en) begin
            if (left.greater) begin
                entry_next = left.entry;
            end else if (left.valid && (greater_o || !cell_valid)) begin
                entry_next = cmd.new_entry;
            end
        end else if (cmd.rem_en && shift_sel) begin
            entry_next = right_entry;
        end
    end

    // Hold entry
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the stable priority sorted list: stream stimulus and scoreboard.
`timescale 1ns / 100ps

import spsl_pkg::*;

// One result as the block should present it
typedef struct packed {
    status_t                      status;
    logic [ENTRY_COUNT_W-1:0]     count;
    logic [LOCATION_W-1:0]        location;
    logic signed [PRIORITY_W-1:0] priority_val;
    logic [LABEL_W-1:0]           label;
} list_result_t;

// Shadow copy of the sorted list plus the queue of results still owed by the block
class sorted_list_scoreboard;
    entry_t       slots [LIST_DEPTH];
    int           fill;
    list_result_t owed_q [$];
    int           errors;
    int           n_ops;
    int           n_full;
    int           n_badpos;
    int           n_reads;
    int           peak_fill;

    function new();
        fill      = 0;
        errors    = 0;
        n_ops     = 0;
        n_full    = 0;
        n_badpos  = 0;
        n_reads   = 0;
        peak_fill = 0;
    endfunction

    function int pending();
        return owed_q.size();
    endfunction

    // Apply one accepted operation to the shadow list and queue its result
    function void note_input(opcode_t op, logic [LOCATION_W-1:0] loc,
                             logic signed [PRIORITY_W-1:0] prio,
                             logic [LABEL_W-1:0] label, logic [POS_W-1:0] pos);
        list_result_t r;
        int           slot;
        r        = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (fill >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    // Walk down past strictly greater priorities; ties stay ahead
                    slot = fill;
                    while (slot > 0 && slots[slot-1].priority_val > prio) begin
                        slots[slot] = slots[slot-1];
                        slot--;
                    end
                    slots[slot].location     = loc;
                    slots[slot].priority_val = prio;
                    slots[slot].label        = label;
                    fill++;
                    if (fill > peak_fill) peak_fill = fill;
                end
            end
            OP_REMOVE: begin
                if (int'(pos) >= fill) begin
                    r.status = ST_BADPOS;
                    n_badpos++;
                end else begin
                    for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                    fill--;
                end
            end
            OP_READ: begin
                if (int'(pos) >= fill) begin
                    r.status = ST_BADPOS;
                    n_badpos++;
                end else begin
                    r.location     = slots[pos].location;
                    r.priority_val = slots[pos].priority_val;
                    r.label        = slots[pos].label;
                    n_reads++;
                end
            end
            default: ;
        endcase
        r.count = fill[ENTRY_COUNT_W-1:0];
        owed_q.push_back(r);
        n_ops++;
    endfunction

    // Compare one result transfer against the oldest owed result
    function void check_result(logic [M_TDATA_W-1:0] d);
        list_result_t got;
        list_result_t want;
        got.status       = status_t'(d[1:0]);
        got.count        = d[6:2];
        got.location     = d[14:7];
        got.priority_val = d[30:15];
        got.label        = d[94:31];
        if (owed_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("[%0t] result with no operation outstanding: status %0d count %0d",
                         $realtime, got.status, got.count);
            return;
        end
        want = owed_q.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.location !== want.location || got.priority_val !== want.priority_val ||
            got.label !== want.label) begin
            errors++;
            if (errors <= 10) begin
                $display("[%0t] mismatch on result %0d:", $realtime, n_ops - owed_q.size());
                $display("    status   exp %0d got %0d", want.status, got.status);
                $display("    count    exp %0d got %0d", want.count, got.count);
                $display("    location exp %0d got %0d", want.location, got.location);
                $display("    priority exp %0d got %0d", want.priority_val, got.priority_val);
                $display("    label    exp %h got %h", want.label, got.label);
            end
        end
    endfunction
endclass

module tb;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // opcode, location, priority_req, label_tag, position, pad
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // status, entry_count, out_location, out_priority, out_label, pad
    logic [M_TDATA_W-1:0]   m_tdata;

    sorted_list_scoreboard sb;
    int n_accepted = 0;
    int burst_left = 1;

    // Receiver pacing state
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  rx_mode   = 0;
    int  mode_left = 0;

    stable_priority_sorted_list u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Offer one operation, wait for its transfer, then maybe pause between bursts
    task automatic push_item(input opcode_t op, input logic [LOCATION_W-1:0] loc,
                             input logic signed [PRIORITY_W-1:0] prio,
                             input logic [LABEL_W-1:0] label, input logic [POS_W-1:0] pos);
        int gap;
        s_tdata  <= {2'b00, pos, label, prio, loc, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, loc, prio, label, pos);
        n_accepted++;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver: one long hold-off once the run is under way, otherwise changing stall modes
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && n_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // Collect each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Stimulus, drain and verdict
    initial begin
        opcode_t                      op;
        logic signed [PRIORITY_W-1:0] prio;
        logic [POS_W-1:0]             pos;
        int                           roll;
        bit                           grow;
        int                           guard;
        sb   = new();
        grow = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list, extremes, ties, remove shift, full list
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd0);
        push_item(OP_REMOVE, 8'd0,   16'sd0,      64'h0, 4'd15);
        push_item(OP_NONE,   8'hFF,  -16'sd1,     '1,    4'd15);
        push_item(OP_ADD,    8'hFF,  16'sh7FFF,   '1,    4'd15);
        push_item(OP_ADD,    8'h00,  -16'sh8000,  64'h0, 4'd0);
        push_item(OP_ADD,    8'd1,   16'sd0,      64'h4142_4344_4546_4748, 4'd0);
        push_item(OP_ADD,    8'd2,   16'sd0,      64'h5051_5253_5455_5657, 4'd0);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd0);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd2);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd3);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd4);
        push_item(OP_REMOVE, 8'd0,   16'sd0,      64'h0, 4'd1);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd1);
        for (int i = 0; i < 13; i++)
            push_item(OP_ADD, 8'(i * 19), 16'(i % 3 - 1), {$urandom, $urandom}, 4'(i));
        push_item(OP_ADD,    8'd77,  16'sd5,      64'hDEAD_BEEF_0000_0001, 4'd0);
        push_item(OP_READ,   8'd0,   16'sd0,      64'h0, 4'd15);
        push_item(OP_REMOVE, 8'd0,   16'sd0,      64'h0, 4'd15);

        // Random: alternate filling and draining phases so both ends of the list are hit
        for (int n = 0; n < 950; n++) begin
            if (n % 120 == 0) grow = ~grow;
            roll = $urandom_range(0, 99);
            if (grow)
                op = (roll < 60) ? OP_ADD : (roll < 75) ? OP_REMOVE :
                     (roll < 96) ? OP_READ : OP_NONE;
            else
                op = (roll < 25) ? OP_ADD : (roll < 65) ? OP_REMOVE :
                     (roll < 95) ? OP_READ : OP_NONE;
            roll = $urandom_range(0, 9);
            if (roll < 5)
                prio = 16'($signed($urandom_range(0, 6)) - 3);
            else if (roll < 8)
                prio = 16'($urandom);
            else
                prio = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sh8000;
            if (sb.fill > 0 && $urandom_range(0, 3) != 0)
                pos = 4'($urandom_range(0, sb.fill - 1));
            else
                pos = 4'($urandom_range(0, 15));
            push_item(op, 8'($urandom), prio, {$urandom, $urandom}, pos);
        end
        s_tvalid <= 1'b0;

        // Drain every owed result, then idle before the verdict
        guard = 0;
        while (sb.pending() > 0 && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);

        if (sb.pending() > 0)
            $display("%0d results never arrived", sb.pending());
        $display("Ran %0d operations, list peaked at %0d entries: %0d reads returned entries,",
                 sb.n_ops, sb.peak_fill, sb.n_reads);
        $display("%0d adds refused on a full list, %0d positions past the end; %0d mismatches",
                 sb.n_full, sb.n_badpos, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("timeout waiting for the list to finish");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spsl_pkg.sv
rtl/spsl_cell.sv
rtl/stable_priority_sorted_list.sv
tb/tb.sv
